// ===== rtl/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the triangle primitive assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

	localparam int unsigned VERT_W      = 32;
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned GATHER_W    = 2;
	localparam int unsigned INDEX_WIDTH_DEF = 32;

	localparam logic [GATHER_W-1:0] GATHER_COUNT = 2'd3;

	// primitive modes; the unused code behaves as strip
	localparam logic [MODE_W-1:0] MODE_LIST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FAN   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIMITIVE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_VALUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_VERTEX    = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] primitive_mode;
		logic              restart_enable;
		logic [VERT_W-1:0] restart_value;
		logic [VERT_W-1:0] base_vertex;
	} tpa_cfg_t;

	typedef struct packed {
		logic              emit;
		logic [VERT_W-1:0] a;
		logic [VERT_W-1:0] b;
		logic [VERT_W-1:0] c;
	} tpa_tri_t;

	typedef struct packed {
		logic [GATHER_W-1:0] gather_remaining;
		logic                flip;
	} tpa_state_t;

endpackage

// ===== rtl/tpa_cfg.sv =====
// ----------------------------------------------------------------------------
// tpa_cfg
// Configuration register file, written by a plain index/data port.
// ----------------------------------------------------------------------------
module tpa_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output tpa_pkg::tpa_cfg_t             cfg
);
	import tpa_pkg::*;

	tpa_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.primitive_mode <= MODE_LIST;
			cfg_q.restart_enable <= 1'b0;
			cfg_q.restart_value  <= '1;
			cfg_q.base_vertex    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRIMITIVE_MODE: cfg_q.primitive_mode <= cfg_data[MODE_W-1:0];
				REG_RESTART_ENABLE: cfg_q.restart_enable <= cfg_data[0];
				REG_RESTART_VALUE:  cfg_q.restart_value  <= cfg_data[VERT_W-1:0];
				REG_BASE_VERTEX:    cfg_q.base_vertex    <= cfg_data[VERT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tpa_core.sv =====
// ----------------------------------------------------------------------------
// tpa_core
// Gather/step state and the per-index assembly logic.
// ----------------------------------------------------------------------------
module tpa_core #(
	parameter int unsigned INDEX_WIDTH = tpa_pkg::INDEX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [INDEX_WIDTH-1:0] idx,
	input  logic                   mesh_start,
	input  tpa_pkg::tpa_cfg_t      cfg,
	output tpa_pkg::tpa_tri_t      tri_out,
	output tpa_pkg::tpa_state_t    status
);
	import tpa_pkg::*;

	logic [VERT_W-1:0]   slot_q [3];
	logic [GATHER_W-1:0] gather_q;
	logic                flip_q;

	logic [VERT_W-1:0]   slot_d [3];
	logic [GATHER_W-1:0] gather_d;
	logic                flip_d;
	logic                emit;
	logic [VERT_W-1:0]   vnum;
	logic                is_list;
	logic                is_fan;
	logic [INDEX_WIDTH-1:0] restart_cut;

	assign vnum        = VERT_W'(idx) + cfg.base_vertex;
	assign is_list     = (cfg.primitive_mode == MODE_LIST);
	assign is_fan      = (cfg.primitive_mode == MODE_FAN);
	assign restart_cut = cfg.restart_value[INDEX_WIDTH-1:0];

	always_comb begin
		logic [GATHER_W-1:0] g;
		logic                f;
		g         = gather_q;
		f         = flip_q;
		slot_d[0] = slot_q[0];
		slot_d[1] = slot_q[1];
		slot_d[2] = slot_q[2];
		emit      = 1'b0;

		if (mesh_start) begin
			g = GATHER_COUNT;
			f = 1'b1;
		end
		if (is_list && g == '0)
			g = GATHER_COUNT;

		if (g != '0) begin
			// gather: fill slot 0, 1, 2 in turn, no restart or degenerate check
			case (g)
				2'd3:    slot_d[0] = vnum;
				2'd2:    slot_d[1] = vnum;
				default: slot_d[2] = vnum;
			endcase
			g = g - 1'b1;
			if (g == '0) begin
				emit = 1'b1;
				if (is_list)
					g = GATHER_COUNT;
			end
		end else if (cfg.restart_enable && idx == restart_cut) begin
			f = 1'b1;
			g = GATHER_COUNT;
		end else begin
			if (is_fan) begin
				slot_d[1] = slot_q[2];
			end else begin
				if (f)
					slot_d[0] = slot_q[2];
				else
					slot_d[1] = slot_q[2];
				f = ~f;
			end
			slot_d[2] = vnum;
			emit = (slot_d[0] != slot_d[1]) && (slot_d[0] != slot_d[2]) &&
			       (slot_d[1] != slot_d[2]);
		end

		gather_d = g;
		flip_d   = f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= GATHER_COUNT;
			flip_q   <= 1'b1;
		end else if (advance) begin
			gather_q <= gather_d;
			flip_q   <= flip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q[0] <= slot_d[0];
			slot_q[1] <= slot_d[1];
			slot_q[2] <= slot_d[2];
		end
	end

	assign tri_out.emit = emit;
	assign tri_out.a    = slot_d[0];
	assign tri_out.b    = slot_d[1];
	assign tri_out.c    = slot_d[2];

	assign status.gather_remaining = gather_q;
	assign status.flip             = flip_q;

endmodule

// ===== rtl/tpa_out_reg.sv =====
// ----------------------------------------------------------------------------
// tpa_out_reg
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
module tpa_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  tpa_pkg::tpa_tri_t           tri_in,
	output logic                        free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpa_pkg::VERT_W-1:0]  corner_a,
	output logic [tpa_pkg::VERT_W-1:0]  corner_b,
	output logic [tpa_pkg::VERT_W-1:0]  corner_c
);
	import tpa_pkg::*;

	logic              valid_q;
	logic [VERT_W-1:0] a_q;
	logic [VERT_W-1:0] b_q;
	logic [VERT_W-1:0] c_q;

	// slot can take a new triangle when empty or being drained this cycle
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= tri_in.emit;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && tri_in.emit) begin
			a_q <= tri_in.a;
			b_q <= tri_in.b;
			c_q <= tri_in.c;
		end
	end

	assign out_valid = valid_q;
	assign corner_a  = a_q;
	assign corner_b  = b_q;
	assign corner_c  = c_q;

endmodule

// ===== rtl/triangle_primitive_assembler.sv =====
// ----------------------------------------------------------------------------
// triangle_primitive_assembler
// Assembles list, strip and fan triangles from a stream of vertex indices.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       vertex_index, mesh_start
//  out      out_valid / out_ready     corner_a, corner_b, corner_c
//  cfg      cfg_we                    cfg_index, cfg_data
//
//  One request per cycle sustained while the result is not stalled. An
//  accepted index is held in an input register and assembled from there;
//  its triangle, if any, is loaded into the result register, which drives
//  out_valid. Reset empties both registers, sets the gather count to 3 and
//  the strip flip flag to 1. A stalled result holds the next item in the
//  input register; in_ready is high while that register is empty or the
//  result register is empty or being drained.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler #(
	parameter int unsigned INDEX_WIDTH = tpa_pkg::INDEX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tpa_pkg::VERT_W-1:0]      vertex_index,
	input  logic                           mesh_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tpa_pkg::VERT_W-1:0]      corner_a,
	output logic [tpa_pkg::VERT_W-1:0]      corner_b,
	output logic [tpa_pkg::VERT_W-1:0]      corner_c,
	input  logic                           cfg_we,
	input  logic [tpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tpa_pkg::*;

	tpa_cfg_t   cfg;
	tpa_tri_t   tri_c;
	tpa_state_t status;

	logic                   valid_s1;
	logic [INDEX_WIDTH-1:0] idx_s1;
	logic                   mesh_s1;
	logic                   out_free;
	logic                   advance;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_s1  <= vertex_index[INDEX_WIDTH-1:0];
			mesh_s1 <= mesh_start;
		end
	end

	tpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tpa_core #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.idx        (idx_s1),
		.mesh_start (mesh_s1),
		.cfg        (cfg),
		.tri_out    (tri_c),
		.status     (status)
	);

	tpa_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.tri_in    (tri_c),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c)
	);

	// a result only shows up right after an item was assembled
	a_out_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(advance))
		else $error("out_valid rose without an assembled item");

	// list mode never leaves the gather count empty
	a_list_gathers: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cfg.primitive_mode == MODE_LIST |=> status.gather_remaining != 2'd0)
		else $error("list mode left gather count at zero");

	// a mesh start stores the first corner and restores strip winding
	a_mesh_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mesh_s1 |=> status.gather_remaining == 2'd2 && status.flip)
		else $error("mesh start did not restart the gather");

	// a held result is never overwritten by a new assembly
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
		else $error("assembly advanced into a stalled result");

endmodule

// ===== tb/sv/triangle_primitive_assembler_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_primitive_assembler_tb
// Self-checking bench for list, strip and fan triangle assembly. A directed
// table covers reset, wrap-around, restarts, degenerate steps and every mode.
// Random phases with random register settings, random input gaps and random
// output stalls follow. Each accepted index runs through a behavioral
// assembler, and each emitted triangle is matched against the oldest entry.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import tpa_pkg::*;

	localparam int unsigned IDX_W        = INDEX_WIDTH_DEF;
	localparam logic [31:0] IDX_MASK     = (IDX_W >= 32) ? 32'hFFFF_FFFF
	                                                     : ((32'd1 << IDX_W) - 32'd1);
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned DRAIN        = 4;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned REPORT_MAX   = 10;

	typedef enum logic {ROW_INDEX, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  sel;
		logic [31:0]           value;
		logic                  new_mesh;
		logic                  typed;
		tpa_tri_t              want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [VERT_W-1:0]      vertex_index;
	logic                   mesh_start;
	logic                   out_valid;
	logic                   out_ready;
	logic [VERT_W-1:0]      corner_a;
	logic [VERT_W-1:0]      corner_b;
	logic [VERT_W-1:0]      corner_c;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// assembler model state and its copy of the registers
	logic [MODE_W-1:0]      cur_mode;
	logic                   restart_on;
	logic [31:0]            restart_code;
	logic [31:0]            vertex_base;
	logic [31:0]            corners [3];
	logic [GATHER_W-1:0]    gather_left;
	logic                   strip_flip;

	tpa_tri_t               triangles_due [$];
	logic                   row_typed;
	tpa_tri_t               row_want;
	bit                     steady_send;
	int unsigned            bad_triangles;
	int unsigned            quiet_cycles;

	triangle_primitive_assembler #(
		.INDEX_WIDTH(IDX_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_index(vertex_index),
		.mesh_start  (mesh_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.corner_a    (corner_a),
		.corner_b    (corner_b),
		.corner_c    (corner_c),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// returns 1 when the index closes a triangle
	function automatic bit assemble_index(input logic [31:0] raw, input logic new_mesh,
	                                      output tpa_tri_t shape);
		logic [31:0] idx;
		logic [31:0] vnum;
		bit          list;
		bit          fan;
		idx   = raw & IDX_MASK;
		vnum  = idx + vertex_base;
		list  = (cur_mode == MODE_LIST);
		fan   = (cur_mode == MODE_FAN);
		shape = '0;
		if (new_mesh) begin
			gather_left = GATHER_COUNT;
			strip_flip  = 1'b1;
		end
		if (list && gather_left == 0)
			gather_left = GATHER_COUNT;
		if (gather_left != 0) begin
			// restart codes are plain indices while gathering
			corners[GATHER_COUNT - gather_left] = vnum;
			gather_left = gather_left - 1'b1;
			if (gather_left != 0)
				return 1'b0;
			shape = '{1'b1, corners[0], corners[1], corners[2]};
			if (list)
				gather_left = GATHER_COUNT;
			return 1'b1;
		end
		if (restart_on && idx == (restart_code & IDX_MASK)) begin
			strip_flip  = 1'b1;
			gather_left = GATHER_COUNT;
			return 1'b0;
		end
		if (fan) begin
			corners[1] = corners[2];
		end else begin
			if (strip_flip)
				corners[0] = corners[2];
			else
				corners[1] = corners[2];
			strip_flip = ~strip_flip;
		end
		corners[2] = vnum;
		// repeated corner: slots keep the update, nothing goes out
		if (corners[0] == corners[1] || corners[0] == corners[2] || corners[1] == corners[2])
			return 1'b0;
		shape = '{1'b1, corners[0], corners[1], corners[2]};
		return 1'b1;
	endfunction

	function automatic stim_row_t idx_row(input logic [31:0] v, input logic ms);
		idx_row = '{ROW_INDEX, REG_PRIMITIVE_MODE, v, ms, 1'b0, tpa_tri_t'('0)};
	endfunction

	function automatic stim_row_t known_row(input logic [31:0] v, input logic ms,
	                                        input logic emit, input logic [31:0] a,
	                                        input logic [31:0] b, input logic [31:0] c);
		known_row = '{ROW_INDEX, REG_PRIMITIVE_MODE, v, ms, 1'b1, tpa_tri_t'{emit, a, b, c}};
	endfunction

	function automatic stim_row_t wr_row(input logic [CFG_IDX_W-1:0] sel,
	                                     input logic [31:0] data);
		wr_row = '{ROW_WRITE, sel, data, 1'b0, 1'b0, tpa_tri_t'('0)};
	endfunction

	function automatic int unsigned sender_gap();
		int unsigned r;
		if (steady_send)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// small pool for repeats and degenerate steps, plus restart codes and extremes
	function automatic logic [31:0] pick_index();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 58)
			return $urandom_range(0, 15);
		if (r < 72)
			return restart_code;
		if (r < 82)
			return $urandom;
		if (r < 87)
			return 32'hFFFF_FFFF;
		if (r < 91)
			return 32'h0;
		return 32'hFFFF_FFF0 + $urandom_range(0, 15);
	endfunction

	function automatic logic [31:0] pick_wide(input logic [31:0] near);
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return near + $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_index(input logic [31:0] value, input logic new_mesh,
	                          input logic typed, input tpa_tri_t want);
		int unsigned gap;
		in_valid     <= 1'b1;
		vertex_index <= value;
		mesh_start   <= new_mesh;
		row_typed    <= typed;
		row_want     <= want;
		do @(posedge clk); while (!in_ready);
		gap = sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off requests until every triangle is out and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (triangles_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(posedge clk);
		case (sel)
			REG_PRIMITIVE_MODE: cur_mode     = data[MODE_W-1:0];
			REG_RESTART_ENABLE: restart_on   = data[0];
			REG_RESTART_VALUE:  restart_code = data;
			REG_BASE_VERTEX:    vertex_base  = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
	endtask

	// prediction on accepted requests, checking on accepted triangles, watchdog
	always @(posedge clk) begin : monitor
		tpa_tri_t shape;
		tpa_tri_t want;
		bit       emitted;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				emitted = assemble_index(vertex_index, mesh_start, shape);
				if (row_typed) begin
					if (row_want.emit)
						triangles_due.push_back(row_want);
				end else if (emitted) begin
					triangles_due.push_back(shape);
				end
			end
			if (out_valid && out_ready) begin
				if (triangles_due.size() == 0) begin
					bad_triangles++;
					if (bad_triangles <= REPORT_MAX)
						$display("%0t: unexpected triangle %h %h %h",
						         $realtime, corner_a, corner_b, corner_c);
				end else begin
					want = triangles_due.pop_front();
					if (corner_a !== want.a || corner_b !== want.b || corner_c !== want.c) begin
						bad_triangles++;
						if (bad_triangles <= REPORT_MAX)
							$display("%0t: triangle exp %h %h %h got %h %h %h", $realtime,
							         want.a, want.b, want.c, corner_a, corner_b, corner_c);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[triangle_primitive_assembler] ERROR");
				$finish;
			end
		end
	end

	// output side: ready runs of random length, short stalls mostly, a few long
	initial begin : drain_side
		int unsigned run;
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	initial begin : stimulus
		stim_row_t   directed [$];
		int unsigned sent;
		int unsigned burst;
		int unsigned r;
		logic        new_mesh;
		logic [MODE_W-1:0] mode;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		vertex_index  = '0;
		mesh_start    = 1'b0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		row_typed     = 1'b0;
		row_want      = '0;
		steady_send   = 1'b0;
		bad_triangles = 0;
		quiet_cycles  = 0;
		cur_mode      = MODE_LIST;
		restart_on    = 1'b0;
		restart_code  = 32'hFFFF_FFFF;
		vertex_base   = 32'h0;
		corners       = '{32'h0, 32'h0, 32'h0};
		gather_left   = GATHER_COUNT;
		strip_flip    = 1'b1;

		directed = '{
			// list mode straight out of reset, index extremes
			known_row(32'h0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0),
			known_row(32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0),
			known_row(32'h5, 1'b0, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h5),
			idx_row(32'h1, 1'b0),                           // left hanging
			idx_row(32'h7, 1'b1),                           // mesh start drops it
			idx_row(32'h8, 1'b0),
			known_row(32'h9, 1'b0, 1'b1, 32'h7, 32'h8, 32'h9),
			// strip with base wrapping and restarts
			wr_row(REG_BASE_VERTEX, 32'hFFFF_FFFF),
			wr_row(REG_PRIMITIVE_MODE, 32'(MODE_STRIP)),
			wr_row(REG_RESTART_ENABLE, 32'h1),
			wr_row(REG_RESTART_VALUE, 32'h10),
			idx_row(32'h1, 1'b1),
			idx_row(32'h2, 1'b0),
			known_row(32'h3, 1'b0, 1'b1, 32'h0, 32'h1, 32'h2),
			idx_row(32'h4, 1'b0),
			idx_row(32'h10, 1'b0),                          // restart
			idx_row(32'h10, 1'b0),                          // stored while gathering
			idx_row(32'h5, 1'b0),
			idx_row(32'h6, 1'b0),
			idx_row(32'h6, 1'b0),                           // repeated corner
			// fan
			wr_row(REG_BASE_VERTEX, 32'h0),
			wr_row(REG_PRIMITIVE_MODE, 32'(MODE_FAN)),
			idx_row(32'h1, 1'b1),
			idx_row(32'h2, 1'b0),
			known_row(32'h3, 1'b0, 1'b1, 32'h1, 32'h2, 32'h3),
			idx_row(32'h4, 1'b0),
			idx_row(32'h4, 1'b0),
			// spare mode code acts as strip, then back to list mid-strip
			wr_row(REG_PRIMITIVE_MODE, 32'(MODE_SPARE)),
			idx_row(32'h0, 1'b1),
			idx_row(32'h1, 1'b0),
			idx_row(32'h2, 1'b0),
			wr_row(REG_PRIMITIVE_MODE, 32'(MODE_LIST)),
			idx_row(32'h3, 1'b0),
			idx_row(32'h4, 1'b0),
			idx_row(32'h5, 1'b0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE)
				write_reg(directed[i].sel, directed[i].value);
			else
				push_index(directed[i].value, directed[i].new_mesh,
				           directed[i].typed, directed[i].want);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			mode = (r < 3) ? MODE_LIST : (r < 6) ? MODE_STRIP : (r < 9) ? MODE_FAN : MODE_SPARE;
			write_reg(REG_PRIMITIVE_MODE, 32'(mode));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RESTART_ENABLE, 32'($urandom_range(0, 9) < 7));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_RESTART_VALUE, pick_wide(32'h0));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_BASE_VERTEX, pick_wide(32'hFFFF_FFF8));
			steady_send = ($urandom_range(0, 4) == 0);
			burst = $urandom_range(10, 60);
			for (int unsigned k = 0; k < burst; k++) begin
				if (k == 0)
					new_mesh = ($urandom_range(0, 9) < 7);
				else
					new_mesh = ($urandom_range(0, 39) == 0);
				push_index(pick_index(), new_mesh, 1'b0, tpa_tri_t'('0));
			end
			steady_send = 1'b0;
			sent += burst;
		end

		settle();
		repeat (DRAIN) @(posedge clk);
		if (bad_triangles == 0)
			$display("[triangle_primitive_assembler] OK");
		else
			$display("[triangle_primitive_assembler] ERROR");
		$finish;
	end

endmodule
